/* rtl/bfpf_pkg.sv */
// shared types, constants and helpers for the body frame pd force block
package bfpf_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_GAIN_POS        = 3'd0;
	localparam logic [2:0] CFG_GAIN_VEL        = 3'd1;
	localparam logic [2:0] CFG_VEHICLE_MASS    = 3'd2;
	localparam logic [2:0] CFG_TARGET_POSITION = 3'd3;
	localparam logic [2:0] CFG_TARGET_VELOCITY = 3'd4;
	localparam logic [2:0] CFG_TARGET_ACCEL    = 3'd5;

	localparam int CFG_DATA_W = 48;
	localparam int CFG_IDX_W  = 3;

	// fixed point widths
	typedef logic signed [15:0] q16_t;    // Q8.8 or Q1.14 input
	typedef logic signed [16:0] err_t;    // Q8.8 error, exact
	typedef logic signed [31:0] prod_t;   // quaternion component product
	typedef logic signed [34:0] rot_t;    // rotation matrix entry, Q.28
	typedef logic signed [51:0] term_t;   // matrix entry times error, Q.36
	typedef logic signed [53:0] acc_t;    // sum of three terms plus rounding
	typedef logic signed [33:0] rerr_t;   // rotated error, Q.16
	typedef logic signed [50:0] gterm_t;  // gain times rotated error, Q.24
	typedef logic signed [32:0] mterm_t;  // mass times accel, Q.16
	typedef logic signed [53:0] fsum_t;   // force sum before rounding, Q.24
	typedef logic signed [23:0] force_t;  // Q16.8 force

	localparam rot_t  ONE_Q28   = rot_t'(268435456);
	localparam acc_t  ROT_HALF  = acc_t'(524288);
	localparam fsum_t FORCE_HALF = fsum_t'(32768);
	localparam force_t FORCE_MAX = 24'sh7FFFFF;
	localparam force_t FORCE_MIN = 24'sh800000;

	// configuration registers as one bundle
	typedef struct packed {
		logic [15:0] gain_pos;
		logic [15:0] gain_vel;
		logic [15:0] vehicle_mass;
		logic [47:0] target_position;
		logic [47:0] target_velocity;
		logic [47:0] target_accel;
	} cfg_t;

	// one input transaction
	typedef struct {
		q16_t pos [3];
		q16_t vel [3];
		q16_t qw;
		q16_t qx;
		q16_t qy;
		q16_t qz;
	} pose_t;

	// stage 1: errors and quaternion products
	typedef struct {
		err_t  pe [3];
		err_t  ve [3];
		prod_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
	} qprod_t;

	// stage 2: rotation matrix and errors
	typedef struct {
		rot_t r  [3][3];
		err_t pe [3];
		err_t ve [3];
	} rmat_t;

	// stage 3: matrix times error partial products
	typedef struct {
		term_t tp [3][3];
		term_t tv [3][3];
	} rterm_t;

	// stage 4: rounded body frame errors
	typedef struct {
		rerr_t sp [3];
		rerr_t sv [3];
	} berr_t;

	// stage 5: gain and feedforward products
	typedef struct {
		gterm_t gp [3];
		gterm_t gv [3];
		mterm_t ma [3];
	} fterm_t;

	// signed Q8.8 half k of a packed xyz register
	function automatic q16_t half16(input logic [47:0] packed_v, input int k);
		return q16_t'(packed_v[16*k +: 16]);
	endfunction

	// diagonal entry: one minus twice the sum of two squares
	function automatic rot_t rot_diag(input prod_t a, input prod_t b);
		return ONE_Q28 - ((rot_t'(a) + rot_t'(b)) <<< 1);
	endfunction

	// off diagonal entry: twice the sum or difference of two products
	function automatic rot_t rot_off(input prod_t a, input prod_t b, input logic sub);
		rot_t s;
		s = sub ? (rot_t'(a) - rot_t'(b)) : (rot_t'(a) + rot_t'(b));
		return s <<< 1;
	endfunction

endpackage

/* rtl/bfpf_qmat.sv */
// stages 1 and 2: world frame errors and rotation matrix of the conjugate quaternion
module bfpf_qmat import bfpf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  pose_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output rmat_t out_data
);

	logic   valid_s1, valid_s2;
	logic   ready_s1, ready_s2;
	qprod_t data_s1, nxt_s1;
	rmat_t  data_s2, nxt_s2;

	// stall chain
	assign ready_s2 = !valid_s2 || out_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// errors and component products
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nxt_s1.pe[i] = err_t'(half16(cfg.target_position, i)) - err_t'(in_data.pos[i]);
			nxt_s1.ve[i] = err_t'(half16(cfg.target_velocity, i)) - err_t'(in_data.vel[i]);
		end
		nxt_s1.xx = prod_t'(in_data.qx) * prod_t'(in_data.qx);
		nxt_s1.yy = prod_t'(in_data.qy) * prod_t'(in_data.qy);
		nxt_s1.zz = prod_t'(in_data.qz) * prod_t'(in_data.qz);
		nxt_s1.xy = prod_t'(in_data.qx) * prod_t'(in_data.qy);
		nxt_s1.xz = prod_t'(in_data.qx) * prod_t'(in_data.qz);
		nxt_s1.yz = prod_t'(in_data.qy) * prod_t'(in_data.qz);
		nxt_s1.wx = prod_t'(in_data.qw) * prod_t'(in_data.qx);
		nxt_s1.wy = prod_t'(in_data.qw) * prod_t'(in_data.qy);
		nxt_s1.wz = prod_t'(in_data.qw) * prod_t'(in_data.qz);
	end

	// matrix entries of the conjugate rotation
	always_comb begin
		nxt_s2.r[0][0] = rot_diag(data_s1.yy, data_s1.zz);
		nxt_s2.r[0][1] = rot_off(data_s1.xy, data_s1.wz, 1'b0);
		nxt_s2.r[0][2] = rot_off(data_s1.xz, data_s1.wy, 1'b1);
		nxt_s2.r[1][0] = rot_off(data_s1.xy, data_s1.wz, 1'b1);
		nxt_s2.r[1][1] = rot_diag(data_s1.xx, data_s1.zz);
		nxt_s2.r[1][2] = rot_off(data_s1.yz, data_s1.wx, 1'b0);
		nxt_s2.r[2][0] = rot_off(data_s1.xz, data_s1.wy, 1'b0);
		nxt_s2.r[2][1] = rot_off(data_s1.yz, data_s1.wx, 1'b1);
		nxt_s2.r[2][2] = rot_diag(data_s1.xx, data_s1.yy);
		nxt_s2.pe = data_s1.pe;
		nxt_s2.ve = data_s1.ve;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ready_s1) data_s1 <= nxt_s1;
		if (ready_s2) data_s2 <= nxt_s2;
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

/* rtl/bfpf_rotate.sv */
// stages 3 and 4: rotate both errors into the body frame and round to Q.16
module bfpf_rotate import bfpf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  rmat_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output berr_t out_data
);

	logic   valid_s3, valid_s4;
	logic   ready_s3, ready_s4;
	rterm_t data_s3, nxt_s3;
	berr_t  data_s4, nxt_s4;

	// stall chain
	assign ready_s4 = !valid_s4 || out_ready;
	assign ready_s3 = !valid_s3 || ready_s4;
	assign in_ready = ready_s3;

	// one product per matrix entry and error
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nxt_s3.tp[i][j] = term_t'(in_data.r[i][j]) * term_t'(in_data.pe[j]);
				nxt_s3.tv[i][j] = term_t'(in_data.r[i][j]) * term_t'(in_data.ve[j]);
			end
		end
	end

	// row sums, round half up and drop 20 fraction bits
	always_comb begin
		acc_t sp, sv;
		sp = '0;
		sv = '0;
		for (int i = 0; i < 3; i++) begin
			sp = acc_t'(data_s3.tp[i][0]) + acc_t'(data_s3.tp[i][1])
			     + acc_t'(data_s3.tp[i][2]) + ROT_HALF;
			sv = acc_t'(data_s3.tv[i][0]) + acc_t'(data_s3.tv[i][1])
			     + acc_t'(data_s3.tv[i][2]) + ROT_HALF;
			nxt_s4.sp[i] = rerr_t'(sp[53:20]);
			nxt_s4.sv[i] = rerr_t'(sv[53:20]);
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready_s3) valid_s3 <= in_valid;
			if (ready_s4) valid_s4 <= valid_s3;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ready_s3) data_s3 <= nxt_s3;
		if (ready_s4) data_s4 <= nxt_s4;
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

/* rtl/bfpf_force.sv */
// stages 5 and 6: gains, feedforward term, rounding and saturation
module bfpf_force import bfpf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	output logic   in_ready,
	input  berr_t  in_data,
	output logic   out_valid,
	input  logic   out_ready,
	output force_t out_force [3]
);

	logic   valid_s5, valid_s6;
	logic   ready_s5, ready_s6;
	fterm_t data_s5, nxt_s5;
	force_t force_s6 [3];
	force_t nxt_s6 [3];

	// stall chain
	assign ready_s6 = !valid_s6 || out_ready;
	assign ready_s5 = !valid_s5 || ready_s6;
	assign in_ready = ready_s5;

	// gain and mass products, unsigned registers widened with a zero sign bit
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nxt_s5.gp[i] = gterm_t'(signed'({1'b0, cfg.gain_pos})) * gterm_t'(in_data.sp[i]);
			nxt_s5.gv[i] = gterm_t'(signed'({1'b0, cfg.gain_vel})) * gterm_t'(in_data.sv[i]);
			nxt_s5.ma[i] = mterm_t'(signed'({1'b0, cfg.vehicle_mass}))
			               * mterm_t'(half16(cfg.target_accel, i));
		end
	end

	// sum, round to Q.8 and clamp to 24 bits
	always_comb begin
		fsum_t       f;
		logic [37:0] q;
		f = '0;
		q = '0;
		for (int i = 0; i < 3; i++) begin
			f = fsum_t'(data_s5.gp[i]) + fsum_t'(data_s5.gv[i])
			    - (fsum_t'(data_s5.ma[i]) <<< 8) + FORCE_HALF;
			q = f[53:16];
			if (q[37:23] == {15{q[37]}}) begin
				nxt_s6[i] = force_t'(q[23:0]);
			end else if (q[37]) begin
				nxt_s6[i] = FORCE_MIN;
			end else begin
				nxt_s6[i] = FORCE_MAX;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (ready_s5) valid_s5 <= in_valid;
			if (ready_s6) valid_s6 <= valid_s5;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (ready_s5) data_s5 <= nxt_s5;
		if (ready_s6) force_s6 <= nxt_s6;
	end

	assign out_valid = valid_s6;
	assign out_force = force_s6;

endmodule

/* rtl/body_frame_pd_force.sv */
// top level of the body frame pd force block: config registers and pipeline
//
//  channel  direction  handshake            payload
//  in       input      in_valid/in_ready    pos_x..z, vel_x..z, quat_w..z
//  out      output     out_valid/out_ready  force_x, force_y, force_z
//  cfg      input      cfg_we               cfg_index, cfg_data
//
// six register stages: products, matrix, rotation products, rounded errors,
// gain products, rounded and saturated force; one transaction is taken
// every cycle while the output side keeps up
// each stage holds while the stage after it is full and stalled
// reset clears all valid bits and sets the registers to unity gains and mass and zero targets
module body_frame_pd_force import bfpf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    pos_x,
	input  logic signed [15:0]    pos_y,
	input  logic signed [15:0]    pos_z,
	input  logic signed [15:0]    vel_x,
	input  logic signed [15:0]    vel_y,
	input  logic signed [15:0]    vel_z,
	input  logic signed [15:0]    quat_w,
	input  logic signed [15:0]    quat_x,
	input  logic signed [15:0]    quat_y,
	input  logic signed [15:0]    quat_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [23:0]    force_x,
	output logic signed [23:0]    force_y,
	output logic signed [23:0]    force_z
);

	cfg_t   cfg_q;
	pose_t  pose;
	rmat_t  rmat;
	berr_t  berr;
	logic   rmat_valid, rmat_ready;
	logic   berr_valid, berr_ready;
	force_t force_out [3];

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_pos        <= 16'd256;
			cfg_q.gain_vel        <= 16'd256;
			cfg_q.vehicle_mass    <= 16'd256;
			cfg_q.target_position <= '0;
			cfg_q.target_velocity <= '0;
			cfg_q.target_accel    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GAIN_POS:        cfg_q.gain_pos        <= cfg_data[15:0];
				CFG_GAIN_VEL:        cfg_q.gain_vel        <= cfg_data[15:0];
				CFG_VEHICLE_MASS:    cfg_q.vehicle_mass    <= cfg_data[15:0];
				CFG_TARGET_POSITION: cfg_q.target_position <= cfg_data;
				CFG_TARGET_VELOCITY: cfg_q.target_velocity <= cfg_data;
				CFG_TARGET_ACCEL:    cfg_q.target_accel    <= cfg_data;
				default: ;
			endcase
		end
	end

	// gather the input transaction
	always_comb begin
		pose.pos[0] = pos_x;
		pose.pos[1] = pos_y;
		pose.pos[2] = pos_z;
		pose.vel[0] = vel_x;
		pose.vel[1] = vel_y;
		pose.vel[2] = vel_z;
		pose.qw     = quat_w;
		pose.qx     = quat_x;
		pose.qy     = quat_y;
		pose.qz     = quat_z;
	end

	bfpf_qmat u_qmat (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (pose),
		.out_valid (rmat_valid),
		.out_ready (rmat_ready),
		.out_data  (rmat)
	);

	bfpf_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rmat_valid),
		.in_ready  (rmat_ready),
		.in_data   (rmat),
		.out_valid (berr_valid),
		.out_ready (berr_ready),
		.out_data  (berr)
	);

	bfpf_force u_force (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (berr_valid),
		.in_ready  (berr_ready),
		.in_data   (berr),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_force (force_out)
	);

	assign force_x = force_out[0];
	assign force_y = force_out[1];
	assign force_z = force_out[2];

endmodule
